// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SVNA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SVNA_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SVNA_ASSERT(lbl, clk, rst, prop, msg)
`define SVNA_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== design/svna_pkg.sv =====
// Shared constants and types of the smoothed vertex normal accumulator.
`default_nettype none
package svna_pkg;

  localparam int DEF_MAX_VERTICES = 1024;

  localparam int IN_IDX_W = 10;
  localparam int VEC_W    = 36;   // accumulated or cross-product component
  localparam int MUL_W    = 31;
  localparam int PROD_W   = 62;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_TRI    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic busy;
    logic done;
    logic deg;
  } norm_stat_t;

endpackage
`default_nettype wire

// ===== design/smooth_vertex_normal_accumulator.sv =====
// Top level of the smoothed vertex normal accumulator.
// One item is taken at a time; in_ready is high only while the block is idle.
// A load and an unused command each pass through S_RED and S_DISP. A clear does
// the same and then zeroes every entry of the use-count memory in one pass, and
// the same pass follows reset before the first item is taken. A triangle reads
// its corners and forms the cross product, then normalises the face. Each corner
// then has a count and normal read, an update and a result, plus any wait on the
// consumer; a corner already in use adds an accumulation through the multiplier
// and a second normalisation. Every normalisation occupies the shared normaliser
// and multiplier; a zero vector goes straight to the result, and otherwise it
// runs up to 29 shift steps, 4 steps for the sum of squares, 32 square-root
// steps and 48 divide steps.
`default_nettype none
`include "assert_macros.svh"
module smooth_vertex_normal_accumulator #(
  parameter int MAX_VERTICES = svna_pkg::DEF_MAX_VERTICES
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [1:0]         cmd,
  input  wire  [9:0]         index_a,
  input  wire  [9:0]         index_b,
  input  wire  [9:0]         index_c,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] pos_z,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [9:0]         vertex_index,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               degenerate,
  output logic               last
);

  localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int RECIP = (1 << 21) / MAX_VERTICES + 1;
  localparam logic [IW-1:0] LAST_ENTRY = IW'(MAX_VERTICES - 1);

  typedef enum logic [14:0] {
    S_CLEAR = 15'b000000000000001,
    S_IDLE  = 15'b000000000000010,
    S_RED   = 15'b000000000000100,
    S_DISP  = 15'b000000000001000,
    S_RDA   = 15'b000000000010000,
    S_RDB   = 15'b000000000100000,
    S_RDC   = 15'b000000001000000,
    S_EDGE  = 15'b000000010000000,
    S_CROSS = 15'b000000100000000,
    S_FNORM = 15'b000001000000000,
    S_CRD   = 15'b000010000000000,
    S_CUPD  = 15'b000100000000000,
    S_ACC   = 15'b001000000000000,
    S_ANORM = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t      state;
  logic [1:0]  cmd_r;
  logic [9:0]  raw [3];
  logic [47:0] pos_r;
  logic [8:0]  q [3];
  logic [IW-1:0] idx [3];
  logic [1:0]  k;
  logic [2:0]  j;
  logic [IW-1:0] clr_cnt;
  logic [47:0] pa;
  logic [47:0] pb;
  logic signed [16:0] e1 [3];
  logic signed [16:0] e2 [3];
  logic signed [35:0] cr [3];
  logic signed [15:0] face [3];
  logic        face_deg;
  logic [15:0] w;
  logic [47:0] old;
  logic signed [35:0] acc [3];
  logic signed [15:0] res_x;
  logic signed [15:0] res_y;
  logic signed [15:0] res_z;
  logic        res_deg;
  logic        norm_go;

  // memories
  logic [47:0] pos_mem [MAX_VERTICES];
  logic [47:0] nrm_mem [MAX_VERTICES];
  logic [15:0] cnt_mem [MAX_VERTICES];
  logic [47:0] pos_rdata;
  logic [47:0] nrm_rdata;
  logic [15:0] cnt_rdata;
  logic        pos_we;
  logic [IW-1:0] pos_raddr;
  logic        cnt_we;
  logic [IW-1:0] cnt_waddr;
  logic [15:0] cnt_wdata;
  logic        nrm_we;
  logic [47:0] nrm_wdata;

  logic [IW-1:0] ridx [3];
  logic [IW-1:0] cur_idx;
  logic [15:0] n_cnt;

  logic signed [svna_pkg::MUL_W-1:0]  t_a;
  logic signed [svna_pkg::MUL_W-1:0]  t_b;
  logic signed [svna_pkg::MUL_W-1:0]  n_a;
  logic signed [svna_pkg::MUL_W-1:0]  n_b;
  logic signed [svna_pkg::MUL_W-1:0]  mul_a;
  logic signed [svna_pkg::MUL_W-1:0]  mul_b;
  logic signed [svna_pkg::PROD_W-1:0] mul_p;
  logic signed [35:0] prod36;

  logic signed [svna_pkg::VEC_W-1:0] vin_x;
  logic signed [svna_pkg::VEC_W-1:0] vin_y;
  logic signed [svna_pkg::VEC_W-1:0] vin_z;
  logic signed [15:0] nout_x;
  logic signed [15:0] nout_y;
  logic signed [15:0] nout_z;
  svna_pkg::norm_stat_t nstat;

  function automatic logic signed [16:0] sx17(input logic [15:0] v);
    return $signed({v[15], v});
  endfunction

  function automatic logic signed [30:0] sx31(input logic signed [16:0] v);
    return $signed({{14{v[16]}}, v});
  endfunction

  // index reduction: multiply by reciprocal, then one subtract
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [25:0] qm;
      logic [9:0]  rdiff;
      qm      = 26'(q[i]) * 26'(MAX_VERTICES);
      rdiff   = raw[i] - qm[9:0];
      ridx[i] = IW'(rdiff);
    end
  end

  always_comb begin
    case (k)
      2'd0:    cur_idx = idx[0];
      2'd1:    cur_idx = idx[1];
      default: cur_idx = idx[2];
    endcase
    n_cnt  = (cnt_rdata == svna_pkg::COUNT_MAX) ? cnt_rdata : cnt_rdata + 16'd1;
    prod36 = mul_p[35:0];

    case (state)
      S_RDB:   pos_raddr = idx[1];
      S_RDC:   pos_raddr = idx[2];
      default: pos_raddr = idx[0];
    endcase
    pos_we    = (state == S_DISP) && (cmd_r == svna_pkg::CMD_LOAD);
    cnt_we    = (state == S_CLEAR) || (state == S_CUPD);
    cnt_waddr = (state == S_CLEAR) ? clr_cnt : cur_idx;
    cnt_wdata = (state == S_CLEAR) ? 16'd0 : n_cnt;
    nrm_we    = ((state == S_CUPD) && (cnt_rdata == 16'd0)) ||
                ((state == S_ANORM) && nstat.done);
    nrm_wdata = (state == S_CUPD) ? {face[2], face[1], face[0]}
                                  : {nout_z, nout_y, nout_x};

    if (state == S_ACC) begin
      t_a = $signed({15'd0, w});
      case (j)
        3'd0:    t_b = sx31(sx17(old[15:0]));
        3'd1:    t_b = sx31(sx17(old[31:16]));
        default: t_b = sx31(sx17(old[47:32]));
      endcase
    end else begin
      case (j)
        3'd1:    begin t_a = sx31(e1[2]); t_b = sx31(e2[1]); end
        3'd2:    begin t_a = sx31(e1[2]); t_b = sx31(e2[0]); end
        3'd3:    begin t_a = sx31(e1[0]); t_b = sx31(e2[2]); end
        3'd4:    begin t_a = sx31(e1[0]); t_b = sx31(e2[1]); end
        3'd5:    begin t_a = sx31(e1[1]); t_b = sx31(e2[0]); end
        default: begin t_a = sx31(e1[1]); t_b = sx31(e2[2]); end
      endcase
    end
    mul_a = nstat.busy ? n_a : t_a;
    mul_b = nstat.busy ? n_b : t_b;

    if (state == S_ANORM) begin
      vin_x = acc[0];
      vin_y = acc[1];
      vin_z = acc[2];
    end else begin
      vin_x = cr[0];
      vin_y = cr[1];
      vin_z = cr[2];
    end
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[ridx[0]] <= pos_r;
    pos_rdata <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cur_idx];
  end

  always_ff @(posedge clk) begin
    if (nrm_we) nrm_mem[cur_idx] <= nrm_wdata;
    nrm_rdata <= nrm_mem[cur_idx];
  end

  svna_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  svna_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .start  (norm_go),
    .vin_x  (vin_x),
    .vin_y  (vin_y),
    .vin_z  (vin_z),
    .nout_x (nout_x),
    .nout_y (nout_y),
    .nout_z (nout_z),
    .stat   (nstat),
    .mul_a  (n_a),
    .mul_b  (n_b),
    .mul_p  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      k       <= 2'd0;
      j       <= 3'd0;
      norm_go <= 1'b0;
    end else begin
      norm_go <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ENTRY) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r  <= cmd;
            raw[0] <= index_a;
            raw[1] <= index_b;
            raw[2] <= index_c;
            pos_r  <= {pos_z, pos_y, pos_x};
            state  <= S_RED;
          end
        end
        S_RED: begin
          for (int i = 0; i < 3; i++) begin
            logic [29:0] tq;
            tq   = 30'(raw[i]) * 30'(RECIP);
            q[i] <= tq[29:21];
          end
          state <= S_DISP;
        end
        S_DISP: begin
          for (int i = 0; i < 3; i++) idx[i] <= ridx[i];
          clr_cnt <= '0;
          case (cmd_r)
            svna_pkg::CMD_TRI:   state <= S_RDA;
            svna_pkg::CMD_CLEAR: state <= S_CLEAR;
            default:             state <= S_IDLE;
          endcase
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          pa    <= pos_rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          pb    <= pos_rdata;
          state <= S_EDGE;
        end
        S_EDGE: begin
          e1[0] <= sx17(pb[15:0])  - sx17(pa[15:0]);
          e1[1] <= sx17(pb[31:16]) - sx17(pa[31:16]);
          e1[2] <= sx17(pb[47:32]) - sx17(pa[47:32]);
          e2[0] <= sx17(pos_rdata[15:0])  - sx17(pa[15:0]);
          e2[1] <= sx17(pos_rdata[31:16]) - sx17(pa[31:16]);
          e2[2] <= sx17(pos_rdata[47:32]) - sx17(pa[47:32]);
          j     <= 3'd0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // product of the previous issue lands this cycle
          j <= j + 3'd1;
          case (j)
            3'd1:    cr[0] <= prod36;
            3'd2:    cr[0] <= cr[0] - prod36;
            3'd3:    cr[1] <= prod36;
            3'd4:    cr[1] <= cr[1] - prod36;
            3'd5:    cr[2] <= prod36;
            3'd6:    cr[2] <= cr[2] - prod36;
            default: ;
          endcase
          if (j == 3'd6) begin
            norm_go <= 1'b1;
            state   <= S_FNORM;
          end
        end
        S_FNORM: begin
          if (nstat.done) begin
            face[0]  <= nout_x;
            face[1]  <= nout_y;
            face[2]  <= nout_z;
            face_deg <= nstat.deg;
            k        <= 2'd0;
            state    <= S_CRD;
          end
        end
        S_CRD: state <= S_CUPD;
        S_CUPD: begin
          w   <= n_cnt - 16'd1;
          old <= nrm_rdata;
          if (cnt_rdata == 16'd0) begin
            res_x   <= face[0];
            res_y   <= face[1];
            res_z   <= face[2];
            res_deg <= face_deg;
            state   <= S_OUT;
          end else begin
            j     <= 3'd0;
            state <= S_ACC;
          end
        end
        S_ACC: begin
          j <= j + 3'd1;
          case (j)
            3'd1:    acc[0] <= prod36 + 36'(face[0]);
            3'd2:    acc[1] <= prod36 + 36'(face[1]);
            3'd3:    acc[2] <= prod36 + 36'(face[2]);
            default: ;
          endcase
          if (j == 3'd3) begin
            norm_go <= 1'b1;
            state   <= S_ANORM;
          end
        end
        S_ANORM: begin
          if (nstat.done) begin
            res_x   <= nout_x;
            res_y   <= nout_y;
            res_z   <= nout_z;
            res_deg <= face_deg | nstat.deg;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (k == 2'd2) begin
              state <= S_IDLE;
            end else begin
              k     <= k + 2'd1;
              state <= S_CRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_OUT);
  assign vertex_index = 10'(cur_idx);
  assign normal_x     = res_x;
  assign normal_y     = res_y;
  assign normal_z     = res_z;
  assign degenerate   = res_deg;
  assign last         = (k == 2'd2);

  `SVNA_NEVER(a_ready_with_result, clk, rst, in_ready && out_valid, "input taken while a result is pending")
  `SVNA_ASSERT(a_last_frees, clk, rst, (out_valid && out_ready && last) |=> in_ready, "block not idle after last transaction")
  `SVNA_ASSERT(a_norm_start_idle, clk, rst, norm_go |-> !nstat.busy, "normaliser started while busy")
  `SVNA_ASSERT(a_clear_quiet, clk, rst, (state == S_CLEAR) |-> (!in_ready && !out_valid), "handshake active during clearing pass")

endmodule
`default_nettype wire

// ===== design/svna_mul.sv =====
// Shared registered signed multiplier.
`default_nettype none
module svna_mul (
  input  wire                                   clk,
  input  wire logic signed [svna_pkg::MUL_W-1:0]  a,
  input  wire logic signed [svna_pkg::MUL_W-1:0]  b,
  output logic signed [svna_pkg::PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== design/svna_norm.sv =====
// Iterative vector normaliser: shift, sum of squares, square root, divide.
`default_nettype none
module svna_norm (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    start,
  input  wire logic signed [svna_pkg::VEC_W-1:0]   vin_x,
  input  wire logic signed [svna_pkg::VEC_W-1:0]   vin_y,
  input  wire logic signed [svna_pkg::VEC_W-1:0]   vin_z,
  output logic signed [15:0]                     nout_x,
  output logic signed [15:0]                     nout_y,
  output logic signed [15:0]                     nout_z,
  output svna_pkg::norm_stat_t                   stat,
  output logic signed [svna_pkg::MUL_W-1:0]        mul_a,
  output logic signed [svna_pkg::MUL_W-1:0]        mul_b,
  input  wire logic signed [svna_pkg::PROD_W-1:0]  mul_p
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQRT  = 6'b001000,
    N_DIV   = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_t;

  nstate_t state;
  logic [35:0] m [3];
  logic        neg [3];
  logic [61:0] sum;
  logic [61:0] x;
  logic [62:0] res;
  logic [31:0] r;
  logic [4:0]  sqcnt;
  logic [1:0]  k;
  logic [1:0]  comp;
  logic [3:0]  dstep;
  logic [32:0] rem;
  logic [14:0] dlo;
  logic [14:0] q;
  logic signed [15:0] o [3];
  logic        deg;

  logic [35:0] mx;
  logic [35:0] msel;
  logic [35:0] mcomp;
  logic [62:0] bitv;
  logic [63:0] t;
  logic        ge;
  logic [62:0] res_next;
  logic [61:0] x_next;
  logic [44:0] dividend;
  logic [32:0] sh;
  logic [14:0] q_next;
  logic [32:0] rem_next;
  logic [35:0] vabs [3];
  logic        vneg [3];

  always_comb begin
    mx = (m[0] > m[1]) ? m[0] : m[1];
    if (m[2] > mx) mx = m[2];
    case (k)
      2'd0:    msel = m[0];
      2'd1:    msel = m[1];
      default: msel = m[2];
    endcase
    case (comp)
      2'd0:    mcomp = m[0];
      2'd1:    mcomp = m[1];
      default: mcomp = m[2];
    endcase
    mul_a = $signed({1'b0, msel[29:0]});
    mul_b = $signed({1'b0, msel[29:0]});

    bitv     = 63'(1) << {sqcnt, 1'b0};
    t        = {1'b0, res} + {1'b0, bitv};
    ge       = {2'b00, x} >= t;
    res_next = ge ? ((res >> 1) + bitv) : (res >> 1);
    x_next   = ge ? (x - t[61:0]) : x;

    // rounded quotient: (m * 2^14 + r/2) / r, high part preloaded
    dividend = {1'b0, mcomp[29:0], 14'b0} + 45'(r[31:1]);
    sh       = {rem[31:0], dlo[14]};
    if (sh >= {1'b0, r}) begin
      rem_next = sh - {1'b0, r};
      q_next   = {q[13:0], 1'b1};
    end else begin
      rem_next = sh;
      q_next   = {q[13:0], 1'b0};
    end

    vneg[0] = vin_x[35];
    vneg[1] = vin_y[35];
    vneg[2] = vin_z[35];
    vabs[0] = vin_x[35] ? 36'(-vin_x) : 36'(vin_x);
    vabs[1] = vin_y[35] ? 36'(-vin_y) : 36'(vin_y);
    vabs[2] = vin_z[35] ? 36'(-vin_z) : 36'(vin_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              m[i]   <= vabs[i];
              neg[i] <= vneg[i];
            end
            if ((vabs[0] | vabs[1] | vabs[2]) == 36'd0) begin
              for (int i = 0; i < 3; i++) o[i] <= 16'sd0;
              deg   <= 1'b1;
              state <= N_DONE;
            end else begin
              deg   <= 1'b0;
              state <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30)
          if (mx[35:29] == 7'd0) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
          end else if (|mx[35:30]) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else begin
            k     <= 2'd0;
            sum   <= 62'd0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          k <= k + 2'd1;
          if (k != 2'd0) sum <= sum + $unsigned(mul_p);
          if (k == 2'd3) begin
            x     <= sum + $unsigned(mul_p);
            res   <= 63'd0;
            sqcnt <= 5'd31;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          x     <= x_next;
          res   <= res_next;
          sqcnt <= sqcnt - 5'd1;
          if (sqcnt == 5'd0) begin
            r     <= res_next[31:0];
            comp  <= 2'd0;
            dstep <= 4'd0;
            state <= N_DIV;
          end
        end
        N_DIV: begin
          if (dstep == 4'd0) begin
            rem   <= {3'b000, dividend[44:15]};
            dlo   <= dividend[14:0];
            q     <= 15'd0;
            dstep <= 4'd1;
          end else begin
            rem   <= rem_next;
            dlo   <= {dlo[13:0], 1'b0};
            q     <= q_next;
            dstep <= dstep + 4'd1;
            if (dstep == 4'd15) begin
              case (comp)
                2'd0:    o[0] <= neg[0] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
                2'd1:    o[1] <= neg[1] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
                default: o[2] <= neg[2] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
              endcase
              dstep <= 4'd0;
              comp  <= comp + 2'd1;
              if (comp == 2'd2) state <= N_DONE;
            end
          end
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign nout_x    = o[0];
  assign nout_y    = o[1];
  assign nout_z    = o[2];
  assign stat.busy = (state != N_IDLE);
  assign stat.done = (state == N_DONE);
  assign stat.deg  = deg;

endmodule
`default_nettype wire

// ===== dv/svna_checker.sv =====
// Checker for the smoothed vertex normal accumulator: predicts normals and compares results.
`timescale 1ns / 100ps
module svna_checker (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire [1:0]         cmd,
  input  wire [9:0]         index_a,
  input  wire [9:0]         index_b,
  input  wire [9:0]         index_c,
  input  wire signed [15:0] pos_x,
  input  wire signed [15:0] pos_y,
  input  wire signed [15:0] pos_z,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire [9:0]         vertex_index,
  input  wire signed [15:0] normal_x,
  input  wire signed [15:0] normal_y,
  input  wire signed [15:0] normal_z,
  input  wire               degenerate,
  input  wire               last,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [9:0]         vidx;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               deg;
    logic               lst;
  } corner_t;

  logic signed [15:0] pos_tab [1024][3];
  logic signed [15:0] nrm_tab [1024][3];
  logic [15:0]        uses [1024];
  corner_t            expected_corners [$];

  assign pending = expected_corners.size();

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // returns 1 when the vector is all zero
  function automatic bit unit_vec(input longint v[3], output logic signed [15:0] o[3]);
    longint unsigned m[3], mx, sum, r, q;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    r = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 16384 + r / 2) / r;
      o[i] = (v[i] < 0) ? -16'(q) : 16'(q);
    end
    return 0;
  endfunction

  task automatic predict_triangle(input logic [9:0] ia, ib, ic);
    logic [9:0] idx[3];
    longint e1[3], e2[3], cr[3], acc[3];
    logic signed [15:0] face[3], nn[3];
    bit face_deg, d;
    corner_t c;
    idx[0] = ia; idx[1] = ib; idx[2] = ic;
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(pos_tab[ib][i]) - longint'(pos_tab[ia][i]);
      e2[i] = longint'(pos_tab[ic][i]) - longint'(pos_tab[ia][i]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    face_deg = unit_vec(cr, face);
    for (int k = 0; k < 3; k++) begin
      d = face_deg;
      if (uses[idx[k]] != svna_pkg::COUNT_MAX) uses[idx[k]]++;
      if (uses[idx[k]] == 1) begin
        nrm_tab[idx[k]] = face;
      end else begin
        for (int i = 0; i < 3; i++)
          acc[i] = longint'(uses[idx[k]] - 1) * longint'(nrm_tab[idx[k]][i]) + face[i];
        if (unit_vec(acc, nn)) d = 1;
        nrm_tab[idx[k]] = nn;
      end
      c.vidx = idx[k];
      c.nx = nrm_tab[idx[k]][0];
      c.ny = nrm_tab[idx[k]][1];
      c.nz = nrm_tab[idx[k]][2];
      c.deg = d;
      c.lst = (k == 2);
      expected_corners = {expected_corners, c};
    end
  endtask

  always @(posedge clk) begin
    corner_t e;
    if (rst) begin
      fail_count <= 0;
      for (int i = 0; i < 1024; i++) uses[i] = 0;
      expected_corners.delete();
    end else begin
      if (in_valid && in_ready) begin
        case (cmd)
          svna_pkg::CMD_LOAD: begin
            pos_tab[index_a][0] = pos_x;
            pos_tab[index_a][1] = pos_y;
            pos_tab[index_a][2] = pos_z;
          end
          svna_pkg::CMD_TRI:   predict_triangle(index_a, index_b, index_c);
          svna_pkg::CMD_CLEAR: for (int i = 0; i < 1024; i++) uses[i] = 0;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_corners.size() == 0) begin
          if (fail_count < 10) $display("unexpected result for vertex %0d", vertex_index);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_corners.pop_front();
          if (e.vidx !== vertex_index || e.nx !== normal_x || e.ny !== normal_y ||
              e.nz !== normal_z || e.deg !== degenerate || e.lst !== last) begin
            if (fail_count < 10)
              $display("mismatch exp v%0d (%0d %0d %0d) d%0b l%0b got v%0d (%0d %0d %0d) d%0b l%0b",
                       e.vidx, e.nx, e.ny, e.nz, e.deg, e.lst, vertex_index, normal_x,
                       normal_y, normal_z, degenerate, last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb_smooth_vertex_normal_accumulator.sv =====
// Testbench top: stimulus, idling and verdict for the vertex normal accumulator.
`timescale 1ns / 100ps
module tb_smooth_vertex_normal_accumulator;

  localparam int IDLE_LIMIT = 20000;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0;
  logic [1:0] cmd = svna_pkg::CMD_LOAD;
  logic [9:0] index_a = 0, index_b = 0, index_c = 0;
  logic signed [15:0] pos_x = 0, pos_y = 0, pos_z = 0;
  wire in_ready, out_valid, degenerate, last;
  wire [9:0] vertex_index;
  wire signed [15:0] normal_x, normal_y, normal_z;
  int fail_count, pending;
  int idle_cycles = 0;
  bit loaded [1024];
  int loaded_list [$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  smooth_vertex_normal_accumulator u_top (.*);
  svna_checker u_chk (.*);

  // consumer stalls
  always @(posedge clk) begin
    int gap;
    if (rst) begin
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
        out_ready <= 1;
      end
    end else if (!out_ready && $urandom_range(3) == 0) begin
      out_ready <= 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high between back-to-back transactions; it drops only for a gap
  task automatic send(input logic [1:0] c, input logic [9:0] a, b, cc,
                      input logic signed [15:0] x, y, z, input bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(18);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd <= c; index_a <= a; index_b <= b; index_c <= cc;
    pos_x <= x; pos_y <= y; pos_z <= z;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c == svna_pkg::CMD_LOAD && !loaded[a]) begin
      loaded[a] = 1;
      loaded_list = {loaded_list, int'(a)};
    end
  endtask

  task automatic load(input logic [9:0] a, input logic signed [15:0] x, y, z);
    send(svna_pkg::CMD_LOAD, a, 0, 0, x, y, z, 0);
  endtask

  function automatic logic [9:0] pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  task automatic triangle(input logic [9:0] a, b, c, input bit burst);
    send(svna_pkg::CMD_TRI, a, b, c, 16'($urandom), 16'($urandom), 16'($urandom), burst);
  endtask

  initial begin
    bit burst;
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed: field extremes, degenerate faces, repeated corners, clear, unused cmd
    load(0, 0, 0, 0);
    load(1023, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    load(1, 16'sh8000, 16'sh7FFF, 16'sh8000);
    load(2, 16'sh1000, 0, 0);
    load(3, 0, 16'sh1000, 0);
    load(4, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    triangle(0, 2, 3, 0);
    triangle(0, 3, 2, 0);
    triangle(0, 1023, 1, 0);
    triangle(0, 0, 0, 0);
    triangle(2, 2, 3, 0);
    triangle(1023, 1, 4, 0);
    send(svna_pkg::CMD_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send(svna_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    triangle(0, 2, 3, 0);
    triangle(3, 0, 2, 0);
    // many repeats on the same three vertices to push their counts
    for (int i = 0; i < 6; i++) triangle(0, 2, 3, 1);
    // hold off until everything has drained
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < 228; i++) begin
      burst = ($urandom_range(4) == 0);
      case ($urandom_range(9))
        0, 1: load(10'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: send(svna_pkg::CMD_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), burst);
        3: if ($urandom_range(3) == 0)
             send(svna_pkg::CMD_UNUSED, 10'($urandom), 10'($urandom), 10'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), burst);
           else triangle(pick_loaded(), pick_loaded(), pick_loaded(), burst);
        default: triangle(pick_loaded(), pick_loaded(), pick_loaded(), burst);
      endcase
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+design
design/svna_pkg.sv
design/svna_mul.sv
design/svna_norm.sv
design/smooth_vertex_normal_accumulator.sv
dv/svna_checker.sv
dv/tb_smooth_vertex_normal_accumulator.sv
